// ===== hw/rtl/sgma_pkg.sv =====
package sgma_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned GRAD_W  = 11;
  localparam int unsigned MAG_W   = 8;
  localparam int unsigned ANG_W   = 13;
  localparam int unsigned LW_W    = 11;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // CORDIC datapath
  localparam int unsigned CXY_W   = 26;
  localparam int unsigned CZ_W    = 24;
  localparam int unsigned SQ_W    = 22;
  localparam int unsigned CSTEPS  = 16;
  localparam logic signed [CZ_W-1:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [ANG_W:0]  ANG_MAX = 14'sd3217;
  localparam logic signed [ANG_W:0]  ANG_MIN = -14'sd3217;
  localparam logic signed [ANG_W-1:0] ANG_PI   = 13'sd3217;
  localparam logic signed [ANG_W-1:0] ANG_HALF = 13'sd1609;

  // register map
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [LW_W-1:0] LW_RESET = 11'd512;
  localparam logic [FH_W-1:0] FH_RESET = 13'd512;

  typedef struct packed {
    logic                    done;
    logic [MAG_W-1:0]        magnitude;
    logic signed [ANG_W-1:0] angle;
  } sgma_calc_res_t;

  function automatic logic signed [CZ_W-1:0] atan_q20(input logic [3:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      4'd0:  v = 24'sd823550;
      4'd1:  v = 24'sd486170;
      4'd2:  v = 24'sd256879;
      4'd3:  v = 24'sd130396;
      4'd4:  v = 24'sd65451;
      4'd5:  v = 24'sd32757;
      4'd6:  v = 24'sd16383;
      4'd7:  v = 24'sd8192;
      4'd8:  v = 24'sd4096;
      4'd9:  v = 24'sd2048;
      4'd10: v = 24'sd1024;
      4'd11: v = 24'sd512;
      4'd12: v = 24'sd256;
      4'd13: v = 24'sd128;
      4'd14: v = 24'sd64;
      4'd15: v = 24'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/sgma_if.sv =====
interface sgma_pix_if import sgma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sgma_grad_if import sgma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [MAG_W-1:0]         magnitude;
  logic signed [ANG_W-1:0]  angle;
  logic                     is_border;
  modport source (output valid, output grad_x, output grad_y, output magnitude,
                  output angle, output is_border, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input magnitude,
                  input angle, input is_border, output ready);
endinterface

// ===== hw/rtl/sobel_gradient_magnitude_angle.sv =====
// Channel | Dir | Transaction              | Fields
// in_if   | in  | valid & ready            | pixel
// out_if  | out | valid & ready            | grad_x grad_y magnitude angle is_border
// APB     | in  | psel & penable & pwrite  | paddr (reg at 4*i) pwdata
//
// One pixel at a time: accept, then the line-store read, then the shared CORDIC/root
// unit (squares, 16 steps, finish, done), then the load of the output register;
// border pixels skip the CORDIC/root unit.
// After reset a clearing pass writes zero to all MAX_WIDTH line-store entries;
// in_if.ready stays low during it.
// A result waits in the output register; the next pixel is accepted meanwhile.
module sobel_gradient_magnitude_angle import sgma_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  sgma_pix_if.sink           in_if,
  sgma_grad_if.source        out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_CALC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [LW_W-1:0] lw_r;
  logic [FH_W-1:0] fh_r;
  logic            cfg_wr;
  logic [31:0]     w32, h32;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LINE_WIDTH) ? APB_DW'(lw_r) : APB_DW'(fh_r);

  // saturate to the supported frame size
  always_comb begin
    w32 = 32'(lw_r);
    h32 = 32'(fh_r);
    if (w32 < 32'd3) w32 = 32'd3;
    else if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    if (h32 < 32'd3) h32 = 32'd3;
    else if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= LW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LINE_WIDTH) lw_r <= pwdata[LW_W-1:0];
      else                            fh_r <= pwdata[FH_W-1:0];
    end
  end

  // position counters, line-store and window
  logic [AW-1:0]      col_r, cur_c_r, clr_r;
  logic [RW-1:0]      row_r, cur_r_r;
  logic [AW-1:0]      cc;
  logic [RW-1:0]      rc;
  logic [PIX_W-1:0]   px_r;
  logic [PIX_W-1:0]   win_r [9];
  logic [PIX_W-1:0]   win_nxt [9];
  logic               in_fire, out_fire;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [2*PIX_W-1:0] ram_wdata, ram_rdata;
  logic [PIX_W-1:0]   up, lo;
  logic [AW:0]        c_inc;
  logic [RW:0]        r_inc;
  logic signed [GRAD_W-1:0] gx_c, gy_c, gx_r, gy_r;
  logic               border_c, border_r;
  sgma_calc_res_t     calc_res;
  logic               calc_start;
  logic               out_free;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;
  assign out_free    = !out_if.valid || out_if.ready;

  // a stale position past the current size restarts at zero
  assign cc = (32'(col_r) >= w32) ? '0 : col_r;
  assign rc = (32'(row_r) >= h32) ? '0 : row_r;

  assign up = ram_rdata[2*PIX_W-1:PIX_W];
  assign lo = ram_rdata[PIX_W-1:0];

  always_comb begin
    ram_raddr = cc;
    ram_we    = 1'b0;
    ram_waddr = cur_c_r;
    ram_wdata = {lo, px_r};
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_READ:  ram_we = 1'b1;
      default: ;
    endcase
  end

  sgma_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // window shift and Sobel sums on the new window
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]   = win_r[k*3+1];
      win_nxt[k*3+1] = win_r[k*3+2];
    end
    win_nxt[2] = up;
    win_nxt[5] = lo;
    win_nxt[8] = px_r;
    gx_c = (GRAD_W'(win_nxt[2]) + (GRAD_W'(win_nxt[5]) << 1) + GRAD_W'(win_nxt[8]))
         - (GRAD_W'(win_nxt[0]) + (GRAD_W'(win_nxt[3]) << 1) + GRAD_W'(win_nxt[6]));
    gy_c = (GRAD_W'(win_nxt[6]) + (GRAD_W'(win_nxt[7]) << 1) + GRAD_W'(win_nxt[8]))
         - (GRAD_W'(win_nxt[0]) + (GRAD_W'(win_nxt[1]) << 1) + GRAD_W'(win_nxt[2]));
    border_c = (cur_r_r < RW'(2)) || (cur_c_r < AW'(2));
  end

  assign c_inc = {1'b0, cur_c_r} + (AW+1)'(1);
  assign r_inc = {1'b0, cur_r_r} + (RW+1)'(1);

  assign calc_start = (state_r == S_READ) && !border_c;

  sgma_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_start),
    .gx    (gx_c),
    .gy    (gy_c),
    .res   (calc_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(MAX_WIDTH-1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_READ;
      S_READ:  state_nxt = border_c ? S_DONE : S_CALC;
      S_CALC:  if (calc_res.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (state_r == S_READ) begin
        win_r <= win_nxt;
      end
      if (cfg_wr) begin
        col_r <= '0;
        row_r <= '0;
      end else if (state_r == S_READ) begin
        if (32'(c_inc) >= w32) begin
          col_r <= '0;
          row_r <= (32'(r_inc) >= h32) ? '0 : r_inc[RW-1:0];
        end else begin
          col_r <= c_inc[AW-1:0];
          row_r <= cur_r_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r    <= in_if.pixel;
      cur_c_r <= cc;
      cur_r_r <= rc;
    end
    if (state_r == S_READ) begin
      gx_r     <= gx_c;
      gy_r     <= gy_c;
      border_r <= border_c;
    end
  end

  // output register
  logic                     ov_r;
  logic signed [GRAD_W-1:0] o_gx_r, o_gy_r;
  logic [MAG_W-1:0]         o_mag_r;
  logic signed [ANG_W-1:0]  o_ang_r;
  logic                     o_bd_r;
  logic                     load;

  assign load = (state_r == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load) begin
      ov_r <= 1'b1;
    end else if (out_fire) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_bd_r  <= border_r;
      o_gx_r  <= border_r ? '0 : gx_r;
      o_gy_r  <= border_r ? '0 : gy_r;
      o_mag_r <= border_r ? '0 : calc_res.magnitude;
      o_ang_r <= border_r ? '0 : calc_res.angle;
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.grad_x    = o_gx_r;
  assign out_if.grad_y    = o_gy_r;
  assign out_if.magnitude = o_mag_r;
  assign out_if.angle     = o_ang_r;
  assign out_if.is_border = o_bd_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_READ))
    else $error("accepted pixel did not start a line-store read");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("line-store write outside read-modify-write");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_bd_r) |-> (o_gx_r == '0 && o_gy_r == '0 && o_mag_r == '0 && o_ang_r == '0))
    else $error("border result carries nonzero fields");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (32'(cur_c_r) < w32))
    else $error("column outside line width");
endmodule

// ===== hw/rtl/sgma_ram.sv =====
module sgma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/sgma_calc.sv =====
module sgma_calc import sgma_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [GRAD_W-1:0] gx,
  input  logic signed [GRAD_W-1:0] gy,
  output sgma_calc_res_t           res
);
  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_SQ   = 4'b0010,
    C_ITER = 4'b0100,
    C_FIN  = 4'b1000
  } calc_state_t;

  calc_state_t state_r, state_nxt;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [CXY_W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [CZ_W-1:0]   z_r, z_nxt;
  logic [SQ_W-1:0]          sq_r;
  logic [MAG_W-1:0]         rt_r, rt_nxt;
  logic [3:0]               i_r;
  logic                     done_r;
  logic [MAG_W-1:0]         mag_r;
  logic signed [ANG_W-1:0]  ang_r, ang_nxt;
  logic [MAG_W-1:0]         mag_nxt;

  logic [GRAD_W-1:0]        ax, ay;
  logic signed [2*GRAD_W-1:0] sqx, sqy;
  logic signed [CXY_W-1:0]  dx, dy;
  logic [MAG_W-1:0]         tb, tt;
  logic [2*MAG_W-1:0]       tsq;
  logic signed [CZ_W-1:0]   zf;
  logic signed [CZ_W-1:0]   zr;
  logic signed [ANG_W:0]    q;

  assign ax  = gx[GRAD_W-1] ? GRAD_W'(-gx) : gx;
  assign ay  = gy[GRAD_W-1] ? GRAD_W'(-gy) : gy;
  assign sqx = gx_r * gx_r;
  assign sqy = gy_r * gy_r;

  // one vectoring step and, while i_r[3] is low, one root digit per cycle
  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    if (!y_r[CXY_W-1]) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + atan_q20(i_r);
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - atan_q20(i_r);
    end
    tb  = (i_r[3]) ? '0 : (MAG_W'(8'd128) >> i_r[2:0]);
    tt  = rt_r | tb;
    tsq = tt * tt;
    rt_nxt = (!i_r[3] && (SQ_W'(tsq) <= sq_r)) ? tt : rt_r;
  end

  always_comb begin
    zf = gx_r[GRAD_W-1] ? (PI_Q20 - z_r) : z_r;
    zr = gy_r[GRAD_W-1] ? -zf : zf;
    q  = (ANG_W+1)'((zr + CZ_W'(512)) >>> 10);
    if (gx_r == '0 && gy_r == '0) begin
      ang_nxt = '0;
    end else if (gy_r == '0) begin
      ang_nxt = gx_r[GRAD_W-1] ? ANG_PI : '0;
    end else if (gx_r == '0) begin
      ang_nxt = gy_r[GRAD_W-1] ? -ANG_HALF : ANG_HALF;
    end else if (q > ANG_MAX) begin
      ang_nxt = ANG_MAX[ANG_W-1:0];
    end else if (q < ANG_MIN) begin
      ang_nxt = ANG_MIN[ANG_W-1:0];
    end else begin
      ang_nxt = q[ANG_W-1:0];
    end
    mag_nxt = (sq_r >= SQ_W'(65536)) ? '1 : rt_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE:  if (start) state_nxt = C_SQ;
      C_SQ:    state_nxt = C_ITER;
      C_ITER:  if (i_r == 4'(CSTEPS-1)) state_nxt = C_FIN;
      C_FIN:   state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        if (start) begin
          gx_r <= gx;
          gy_r <= gy;
          x_r  <= CXY_W'({ax, 12'b0});
          y_r  <= CXY_W'({ay, 12'b0});
          z_r  <= '0;
          rt_r <= '0;
          i_r  <= '0;
        end
      end
      C_SQ: begin
        sq_r <= SQ_W'(sqx) + SQ_W'(sqy);
      end
      C_ITER: begin
        x_r  <= x_nxt;
        y_r  <= y_nxt;
        z_r  <= z_nxt;
        rt_r <= rt_nxt;
        i_r  <= i_r + 4'd1;
      end
      C_FIN: begin
        mag_r <= mag_nxt;
        ang_r <= ang_nxt;
      end
      default: ;
    endcase
  end

  assign res.done      = done_r;
  assign res.magnitude = mag_r;
  assign res.angle     = ang_r;
endmodule

// ===== tb/tb_sgma_scoreboard.sv =====
`timescale 1ns / 1ps
// Edge-detector predictor and expected-result queue.
class sgma_scoreboard;
  typedef struct packed {
    logic signed [10:0] grad_x;
    logic signed [10:0] grad_y;
    logic [7:0]         magnitude;
    logic signed [12:0] angle;
    logic               is_border;
  } edge_res_t;

  bit [10:0] line_width;
  bit [12:0] frame_height;
  bit [7:0]  row_above2 [1024];
  bit [7:0]  row_above1 [1024];
  bit [7:0]  win [9];
  int unsigned col, row;
  edge_res_t pending[$];
  int errors;

  function new();
    line_width = 11'd512;
    frame_height = 13'd512;
    foreach (row_above2[i]) begin
      row_above2[i] = '0;
      row_above1[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col = 0;
    row = 0;
    errors = 0;
  endfunction

  function void set_width(bit [10:0] v);
    line_width = v;
    col = 0;
    row = 0;
  endfunction

  function void set_height(bit [12:0] v);
    frame_height = v;
    col = 0;
    row = 0;
  endfunction

  static function longint fshift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  static function int isqrt_sat(int gx, int gy);
    int s, r, t;
    s = gx * gx + gy * gy;
    r = 0;
    if (s >= 65536) return 255;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = r + b;
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  static function int cordic_angle(int gx, int gy);
    longint tq [16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                        8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    longint x, y, z, dx, dy, q;
    if (gx == 0 && gy == 0) return 0;
    if (gy == 0) return gx > 0 ? 0 : 3217;
    if (gx == 0) return gy > 0 ? 1609 : -1609;
    x = (gx < 0 ? -gx : gx) * 4096;
    y = (gy < 0 ? -gy : gy) * 4096;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += tq[i];
      end else begin
        x -= dx; y += dy; z -= tq[i];
      end
    end
    if (gx < 0) z = 3294199 - z;
    if (gy < 0) z = -z;
    q = fshift(z + 512, 10);
    if (q > 3217) q = 3217;
    if (q < -3217) q = -3217;
    return int'(q);
  endfunction

  // note an accepted pixel and queue the result for the window centre
  function void push_pixel(bit [7:0] px);
    int unsigned w, h, c, r;
    bit [7:0] up, lo;
    int gx, gy;
    edge_res_t e;
    w = line_width < 3 ? 3 : (line_width > 1024 ? 1024 : line_width);
    h = frame_height < 3 ? 3 : (frame_height > 4096 ? 4096 : frame_height);
    c = col >= w ? 0 : col;
    r = row >= h ? 0 : row;
    up = row_above2[c];
    lo = row_above1[c];
    row_above2[c] = lo;
    row_above1[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = px;
    e = '0;
    if (r >= 2 && c >= 2) begin
      gx = (int'(win[2]) + 2*int'(win[5]) + int'(win[8]))
         - (int'(win[0]) + 2*int'(win[3]) + int'(win[6]));
      gy = (int'(win[6]) + 2*int'(win[7]) + int'(win[8]))
         - (int'(win[0]) + 2*int'(win[1]) + int'(win[2]));
      e.grad_x = gx[10:0];
      e.grad_y = gy[10:0];
      e.magnitude = 8'(isqrt_sat(gx, gy));
      e.angle = 13'(cordic_angle(gx, gy));
    end else begin
      e.is_border = 1'b1;
    end
    pending.push_back(e);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col = c;
    row = r;
  endfunction

  task report(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  task check_result(edge_res_t got);
    edge_res_t want;
    if (pending.size() == 0) begin
      report("unexpected transaction", 1, 0);
      return;
    end
    want = pending.pop_front();
    if (got.grad_x !== want.grad_x) report("grad_x", got.grad_x, want.grad_x);
    if (got.grad_y !== want.grad_y) report("grad_y", got.grad_y, want.grad_y);
    if (got.magnitude !== want.magnitude)
      report("magnitude", got.magnitude, want.magnitude);
    if (got.angle !== want.angle) report("angle", got.angle, want.angle);
    if (got.is_border !== want.is_border)
      report("is_border", got.is_border, want.is_border);
  endtask
endclass

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top import sgma_pkg::*; ;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  sgma_pix_if  pix_if ();
  sgma_grad_if grad_if ();

  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sobel_gradient_magnitude_angle u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(pix_if.sink), .out_if(grad_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sgma_scoreboard sb = new();

  // register byte addresses (4*index)
  localparam logic [APB_AW-1:0] ADDR_LW = {REG_LINE_WIDTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_FH = {REG_FRAME_HEIGHT, 2'b00};
  // watchdog allows clearing pass + long stall
  localparam int PIX_LATENCY = 30;
  localparam int WATCHDOG = 20000;

  bit  stall_long = 1'b0;   // forces the receiver to hold off
  bit  done = 1'b0;
  int  idle_cycles = 0;

  initial begin
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    grad_if.ready = 1'b0;
  end

  // receiver: own stall pattern, long hold-off on request
  always @(negedge clk) begin
    if (stall_long) grad_if.ready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: grad_if.ready <= 1'b0;
      default: grad_if.ready <= 1'b1;
    endcase
  end

  // sample at rising edge; count idle cycles for the watchdog
  always @(posedge clk) begin
    if (rst_n && grad_if.valid && grad_if.ready)
      sb.check_result({grad_if.grad_x, grad_if.grad_y, grad_if.magnitude,
                       grad_if.angle, grad_if.is_border});
    if (!rst_n || (pix_if.valid && pix_if.ready) ||
        (grad_if.valid && grad_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !done) begin
      $display("watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // APB write: setup then access; also mirrors into the predictor
  task automatic reg_write(logic [APB_AW-1:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_LW) sb.set_width(val[10:0]);
    else sb.set_height(val[12:0]);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one pixel transaction; valid stays high until hold_input
  task automatic send_pixel(bit [7:0] px);
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk); while (!pix_if.ready);
    sb.push_pixel(px);
    @(negedge clk);
  endtask

  // drop valid
  task automatic hold_input();
    pix_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // random bursts with gaps
  task automatic send_frame(int n, int mode);
    int burst, gap;
    bit [7:0] px;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: px = $urandom_range(0, 255);
        1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: px = 8'(i * 37);
      endcase
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      send_pixel(px);
      if (burst == 0 && i != n - 1) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        if (gap != 0) hold_input();
        repeat (gap) @(negedge clk);
      end
    end
    hold_input();
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIX_LATENCY) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset width 512: border results on the first row, then shrink
    send_frame(8, 0);
    drain();
    reg_write(ADDR_LW, 32'd3);
    reg_write(ADDR_FH, 32'd3);
    // directed: extremes in a 3x3 frame - full vertical and horizontal step edges
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) send_pixel((i >= 6) ? 8'hFF : 8'h00);
    hold_input();
    drain();
    // out-of-range registers saturate; also widen
    reg_write(ADDR_LW, 32'h7FF);
    reg_write(ADDR_FH, 32'd0);
    send_frame(6, 1);
    drain();
    reg_write(ADDR_LW, 32'd1);
    reg_write(ADDR_FH, 32'h1FFF);
    send_frame(12, 1);
    drain();

    reg_write(ADDR_LW, 32'd5);
    reg_write(ADDR_FH, 32'd4);
    send_frame(100, 0);
    // long receiver hold-off while input keeps coming
    fork
      begin
        stall_long = 1'b1;
        repeat (300) @(posedge clk);
        stall_long = 1'b0;
      end
      send_frame(40, 1);
    join
    drain();  // sender pause until all results are in

    reg_write(ADDR_LW, 32'd7);
    reg_write(ADDR_FH, 32'd3);
    send_frame(120, 1);
    drain();
    reg_write(ADDR_LW, 32'd4);
    reg_write(ADDR_FH, 32'd5);
    send_frame(120, 0);
    send_frame(20, 2);
    drain();

    done = 1'b1;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
